/* rtl/core/hrpd_pkg.sv */
`timescale 1ns / 1ps

package hrpd_pkg;

    // Default sizes for the top level
    localparam int HISTORY_DEPTH_DEF = 1024;
    localparam int MAX_COLUMNS_DEF   = 64;
    localparam int SAMPLE_BITS_DEF   = 31;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_HISTORY_CAPACITY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT     = 2'd1;

    // Request opcodes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_RENDER = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] download_rate;
        logic signed [31:0] upload_rate;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  column_index;
        logic        column_present;
        logic [30:0] column_download;
        logic [30:0] column_upload;
        logic [30:0] overall_download_max;
        logic [30:0] overall_upload_max;
        logic        last_column;
    } t_out_item;

endpackage

/* rtl/core/hrpd_stream_if.sv */
`timescale 1ns / 1ps

interface hrpd_stream_if
    import hrpd_pkg::*;
#(
    parameter type T = t_in_item
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/hrpd_ram.sv */
`timescale 1ns / 1ps

module hrpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/history_ring_peak_decimator.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload     Transfer
// i_in      in   t_in_item   i_in.valid & i_in.ready
// o_out     out  t_out_item  o_out.valid & o_out.ready
// i_cfg_*   in   index/data  i_cfg_we (no back-pressure)
//
// Append and clear are done in the idle state. A render reads each stored
// sample from the ring (S_W_RD, S_W_ACC), steps the age-to-column mapping in
// S_W_RD (at most column_count-1 steps), flushes the open column, reads each
// result from the column memory and waits in S_E_LD while the sink stalls.
// Reset is synchronous; no clearing pass is needed. Input is held off while
// a render runs; the last result may still wait while new requests are taken.

module history_ring_peak_decimator
    import hrpd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int MAX_COLUMNS   = MAX_COLUMNS_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    hrpd_stream_if.sink            i_in,
    hrpd_stream_if.source          o_out
);
    localparam int AW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CAPW = $clog2(HISTORY_DEPTH + 1);
    localparam int CIW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CNTW = $clog2(MAX_COLUMNS + 1);
    localparam int RW   = ((CAPW > CNTW) ? CAPW : CNTW) + 1;
    localparam int SW   = (SAMPLE_BITS > 31) ? 31 : SAMPLE_BITS;
    localparam logic [63:0] SAMP_LIM = (64'd1 << SAMPLE_BITS) - 64'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_W_RD,
        S_W_ACC,
        S_W_FLUSH,
        S_E_RD,
        S_E_LD
    } t_state;

    t_state             r_state;
    logic [CAPW-1:0]    r_cap;
    logic [CNTW-1:0]    r_cols;
    logic [AW-1:0]      r_wp;
    logic [CAPW-1:0]    r_count;
    logic [AW-1:0]      r_rd_ptr;
    logic [CAPW-1:0]    r_left;
    logic [CNTW-1:0]    r_step;
    logic [RW-1:0]      r_rem;
    logic [CIW-1:0]     r_cur_col;
    logic               r_cur_has;
    logic [SW-1:0]      r_cur_down;
    logic [SW-1:0]      r_cur_up;
    logic [SW-1:0]      r_tot_down;
    logic [SW-1:0]      r_tot_up;
    logic [MAX_COLUMNS-1:0] r_mark;
    logic [CIW-1:0]     r_k;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CAPW-1:0]    smp_span;
    logic [CNTW-1:0]    col_span;
    logic [CIW-1:0]     cur_col;
    logic               in_fire;
    logic               adjust;
    logic               out_free;
    logic               load_out;
    logic               last_k;
    logic [AW-1:0]      slot;
    logic [AW-1:0]      n_wp;
    logic [AW-1:0]      newest;
    logic [AW-1:0]      n_rd_ptr;
    logic [31:0]        n_cap_wide;
    logic [31:0]        n_cols_wide;
    logic [SW-1:0]      s_down;
    logic [SW-1:0]      s_up;
    logic               col_change;

    logic               ring_we;
    logic               ring_re;
    logic [2*SW-1:0]    ring_wdata;
    logic [2*SW-1:0]    ring_rdata;
    logic               col_we;
    logic               col_re;
    logic [2*SW-1:0]    col_rdata;

    // Clamp negatives to zero, saturate to the sample range
    function automatic logic [SW-1:0] clamp_sample(input logic [31:0] raw);
        logic [63:0] v;
        v = {32'b0, raw};
        if (raw[31]) begin
            v = '0;
        end else if (v > SAMP_LIM) begin
            v = SAMP_LIM;
        end
        return SW'(v);
    endfunction

    // Handshakes and spans
    assign in_fire   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free  = !r_out_valid || o_out.ready;
    assign load_out  = (r_state == S_E_LD) && out_free;
    assign smp_span  = r_cap - CAPW'(1);
    assign col_span  = r_cols - CNTW'(1);
    assign cur_col   = CIW'(col_span - r_step);
    assign adjust    = (r_rem >= RW'(smp_span));
    assign last_k    = (CNTW'(r_k) == col_span);
    assign s_down    = ring_rdata[2*SW-1:SW];
    assign s_up      = ring_rdata[SW-1:0];
    assign col_change = r_cur_has && (cur_col != r_cur_col);

    // Ring pointers
    always_comb begin
        slot     = ({1'b0, r_wp} < (AW + 1)'(r_cap)) ? r_wp : '0;
        n_wp     = ((CAPW'(slot) + CAPW'(1)) >= r_cap) ? '0 : slot + AW'(1);
        newest   = (r_wp == '0) ? AW'(r_cap - CAPW'(1)) : r_wp - AW'(1);
        n_rd_ptr = (r_rd_ptr == '0) ? AW'(r_cap - CAPW'(1)) : r_rd_ptr - AW'(1);
    end

    // Saturate configuration values
    always_comb begin
        n_cap_wide = 32'(i_cfg_data);
        if (n_cap_wide < 32'd2) begin
            n_cap_wide = 32'd2;
        end else if (n_cap_wide > 32'(HISTORY_DEPTH)) begin
            n_cap_wide = 32'(HISTORY_DEPTH);
        end
        n_cols_wide = 32'(i_cfg_data[6:0]);
        if (n_cols_wide < 32'd2) begin
            n_cols_wide = 32'd2;
        end else if (n_cols_wide > 32'(MAX_COLUMNS)) begin
            n_cols_wide = 32'(MAX_COLUMNS);
        end
    end

    // Memory controls
    always_comb begin
        ring_we    = in_fire && (i_in.payload.opcode == OP_APPEND);
        ring_wdata = {clamp_sample(i_in.payload.download_rate),
                      clamp_sample(i_in.payload.upload_rate)};
        ring_re    = (r_state == S_W_RD) && !adjust;
        col_we     = ((r_state == S_W_ACC) && col_change) || (r_state == S_W_FLUSH);
        col_re     = (r_state == S_E_RD);
    end

    hrpd_ram #(
        .WIDTH (2 * SW),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (slot),
        .i_wdata (ring_wdata),
        .i_re    (ring_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ring_rdata)
    );

    hrpd_ram #(
        .WIDTH (2 * SW),
        .DEPTH (MAX_COLUMNS)
    ) u_columns (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (r_cur_col),
        .i_wdata ({r_cur_down, r_cur_up}),
        .i_re    (col_re),
        .i_raddr (r_k),
        .o_rdata (col_rdata)
    );

    // Sequencer, history state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAPW'(HISTORY_DEPTH < 1024 ? HISTORY_DEPTH : 1024);
            r_cols      <= CNTW'(MAX_COLUMNS);
            r_wp        <= '0;
            r_count     <= '0;
            r_mark      <= '0;
            r_cur_has   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Hold the result until transferred, then drop it or load the next
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (i_in.payload.opcode)
                            OP_APPEND: begin
                                r_wp <= n_wp;
                                if (r_count < r_cap) begin
                                    r_count <= r_count + CAPW'(1);
                                end
                            end
                            OP_CLEAR: begin
                                r_wp    <= '0;
                                r_count <= '0;
                            end
                            OP_RENDER: begin
                                r_mark     <= '0;
                                r_tot_down <= '0;
                                r_tot_up   <= '0;
                                r_cur_has  <= 1'b0;
                                r_step     <= '0;
                                r_rem      <= '0;
                                r_left     <= r_count;
                                r_rd_ptr   <= newest;
                                r_k        <= '0;
                                r_state    <= (r_count == '0) ? S_E_RD : S_W_RD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_W_RD: begin
                    // Advance the column step until the remainder is in range
                    if (adjust) begin
                        r_rem  <= r_rem - RW'(smp_span);
                        r_step <= r_step + CNTW'(1);
                    end else begin
                        r_state <= S_W_ACC;
                    end
                end
                S_W_ACC: begin
                    // Fold the sample into the open column, close it on change
                    if (col_change) begin
                        r_mark[r_cur_col] <= 1'b1;
                        r_cur_down        <= s_down;
                        r_cur_up          <= s_up;
                    end else begin
                        r_cur_down <= (!r_cur_has || s_down > r_cur_down) ? s_down : r_cur_down;
                        r_cur_up   <= (!r_cur_has || s_up > r_cur_up) ? s_up : r_cur_up;
                    end
                    r_cur_col <= cur_col;
                    r_cur_has <= 1'b1;
                    if (s_down > r_tot_down) begin
                        r_tot_down <= s_down;
                    end
                    if (s_up > r_tot_up) begin
                        r_tot_up <= s_up;
                    end
                    if (r_left == CAPW'(1)) begin
                        r_state <= S_W_FLUSH;
                    end else begin
                        r_left   <= r_left - CAPW'(1);
                        r_rd_ptr <= n_rd_ptr;
                        r_rem    <= r_rem + RW'(col_span);
                        r_state  <= S_W_RD;
                    end
                end
                S_W_FLUSH: begin
                    r_mark[r_cur_col] <= 1'b1;
                    r_state           <= S_E_RD;
                end
                S_E_RD: begin
                    r_state <= S_E_LD;
                end
                S_E_LD: begin
                    // Load one column result when the output register is free
                    if (out_free) begin
                        r_out.column_index         <= 6'(r_k);
                        r_out.column_present       <= r_mark[r_k];
                        r_out.column_download      <= r_mark[r_k] ?
                                                      31'(col_rdata[2*SW-1:SW]) : '0;
                        r_out.column_upload        <= r_mark[r_k] ?
                                                      31'(col_rdata[SW-1:0]) : '0;
                        r_out.overall_download_max <= last_k ? 31'(r_tot_down) : '0;
                        r_out.overall_upload_max   <= last_k ? 31'(r_tot_up) : '0;
                        r_out.last_column          <= last_k;
                        if (last_k) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + CIW'(1);
                            r_state <= S_E_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Register writes; a capacity change empties the history
            if (i_cfg_we) begin
                if (i_cfg_index == REG_HISTORY_CAPACITY) begin
                    if (CAPW'(n_cap_wide) != r_cap) begin
                        r_cap   <= CAPW'(n_cap_wide);
                        r_wp    <= '0;
                        r_count <= '0;
                    end
                end else if (i_cfg_index == REG_COLUMN_COUNT) begin
                    r_cols <= CNTW'(n_cols_wide);
                end
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Checks
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("stored count exceeds capacity");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W_ACC) |-> (r_step <= col_span))
        else $error("column step beyond column span");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.last_column) |->
            (o_out.payload.column_index == 6'(col_span)))
        else $error("last result on wrong column");

    a_totals_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.payload.last_column) |->
            (o_out.payload.overall_download_max == '0 &&
             o_out.payload.overall_upload_max == '0))
        else $error("overall maxima before last result");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import hrpd_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;

    localparam int WATCHDOG_LIMIT    = 20000;
    localparam int SINK_HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES     = 16;
    localparam int END_SETTLE_CYCLES = 64;

    typedef enum int {
        PACE_FREE,
        PACE_COIN,
        PACE_QUARTER,
        PACE_SPARSE_STALL
    } t_pace;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    hrpd_stream_if #(.T(t_in_item))  in_ch ();
    hrpd_stream_if #(.T(t_out_item)) out_ch ();

    history_ring_peak_decimator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Shadow of the history ring and the two registers
    logic [30:0] hist_down [HISTORY_DEPTH_DEF];
    logic [30:0] hist_up   [HISTORY_DEPTH_DEF];
    int unsigned hist_wr   = 0;
    int unsigned hist_fill = 0;
    int unsigned hist_cap  = HISTORY_DEPTH_DEF;
    int unsigned col_count = MAX_COLUMNS_DEF;

    t_out_item pending_columns [$];

    int fault_count   = 0;
    int idle_cycles   = 0;
    int gap_max       = 0;
    int burst_left    = 0;
    bit sink_hold_req = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Negative rates floor at zero; the rest fit in 31 bits as they are
    function automatic logic [30:0] clamp_rate(logic signed [31:0] rate);
        return rate[31] ? 31'd0 : rate[30:0];
    endfunction

    function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        int unsigned v;
        case (idx)
            REG_HISTORY_CAPACITY: begin
                v = 32'(data);
                if (v < 2) v = 2;
                if (v > HISTORY_DEPTH_DEF) v = HISTORY_DEPTH_DEF;
                // A new capacity drops the history
                if (v != hist_cap) begin
                    hist_cap  = v;
                    hist_wr   = 0;
                    hist_fill = 0;
                end
            end
            REG_COLUMN_COUNT: begin
                v = 32'(data[6:0]);
                if (v < 2) v = 2;
                if (v > MAX_COLUMNS_DEF) v = MAX_COLUMNS_DEF;
                col_count = v;
            end
            default: ;
        endcase
    endfunction

    // Update the shadow history and queue the columns a render produces
    function automatic void take_request(t_in_item req);
        logic [30:0] col_down [MAX_COLUMNS_DEF];
        logic [30:0] col_up   [MAX_COLUMNS_DEF];
        bit          col_seen [MAX_COLUMNS_DEF];
        logic [30:0] peak_down;
        logic [30:0] peak_up;
        int unsigned count, oldest, slot, age, c, i;
        t_out_item   res;
        case (req.opcode)
            OP_APPEND: begin
                slot = (hist_wr < hist_cap) ? hist_wr : 0;
                hist_down[slot] = clamp_rate(req.download_rate);
                hist_up[slot]   = clamp_rate(req.upload_rate);
                slot++;
                hist_wr = (slot >= hist_cap) ? 0 : slot;
                if (hist_fill < hist_cap) hist_fill++;
            end
            OP_CLEAR: begin
                hist_wr   = 0;
                hist_fill = 0;
            end
            OP_RENDER: begin
                for (c = 0; c < MAX_COLUMNS_DEF; c++) begin
                    col_down[c] = '0;
                    col_up[c]   = '0;
                    col_seen[c] = 1'b0;
                end
                peak_down = '0;
                peak_up   = '0;
                count  = (hist_fill < hist_cap) ? hist_fill : hist_cap;
                oldest = (hist_wr + hist_cap - count) % hist_cap;
                // Map each sample by age, newest to the rightmost column
                for (i = 0; i < count; i++) begin
                    slot = (oldest + i) % hist_cap;
                    age  = count - 1 - i;
                    c    = (col_count - 1) - age * (col_count - 1) / (hist_cap - 1);
                    if (hist_down[slot] > col_down[c]) col_down[c] = hist_down[slot];
                    if (hist_up[slot] > col_up[c]) col_up[c] = hist_up[slot];
                    col_seen[c] = 1'b1;
                    if (hist_down[slot] > peak_down) peak_down = hist_down[slot];
                    if (hist_up[slot] > peak_up) peak_up = hist_up[slot];
                end
                for (c = 0; c < col_count; c++) begin
                    res.column_index         = 6'(c);
                    res.column_present       = col_seen[c];
                    res.column_download      = col_down[c];
                    res.column_upload        = col_up[c];
                    res.last_column          = (c == col_count - 1);
                    res.overall_download_max = res.last_column ? peak_down : 31'd0;
                    res.overall_upload_max   = res.last_column ? peak_up : 31'd0;
                    pending_columns.push_back(res);
                end
            end
            default: ;
        endcase
    endfunction

    // Follow both channels and check every column transfer
    always @(posedge i_clk) begin : transfer_monitor
        t_out_item want;
        t_out_item got;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            take_request(in_ch.payload);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (pending_columns.size() == 0) begin
                if (fault_count < 10) begin
                    $display("unrequested column transfer: index %0d at %0t",
                             got.column_index, $realtime);
                end
                fault_count++;
            end else begin
                want = pending_columns.pop_front();
                if (got.column_index !== want.column_index ||
                    got.column_present !== want.column_present ||
                    got.column_download !== want.column_download ||
                    got.column_upload !== want.column_upload ||
                    got.overall_download_max !== want.overall_download_max ||
                    got.overall_upload_max !== want.overall_upload_max ||
                    got.last_column !== want.last_column) begin
                    if (fault_count < 10) begin
                        $display("column differs at %0t", $realtime);
                        $display("  want idx %0d pres %0b dn %h up %h max %h/%h last %0b",
                                 want.column_index, want.column_present,
                                 want.column_download, want.column_upload,
                                 want.overall_download_max, want.overall_upload_max,
                                 want.last_column);
                        $display("  got  idx %0d pres %0b dn %h up %h max %h/%h last %0b",
                                 got.column_index, got.column_present,
                                 got.column_download, got.column_upload,
                                 got.overall_download_max, got.overall_upload_max,
                                 got.last_column);
                    end
                    fault_count++;
                end
            end
        end
    end

    // Abort when no transfer happens for too long
    always @(posedge i_clk) begin : watchdog
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("history_ring_peak_decimator: mismatch");
            $finish;
        end
    end

    // Pace the column sink; hold off fully on request
    initial begin : sink_pacing
        int    stretch_left;
        int    slot_count;
        t_pace pace_mode;
        stretch_left = 0;
        slot_count   = 0;
        pace_mode    = PACE_FREE;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                sink_hold_req = 1'b0;
            end
            if (stretch_left == 0) begin
                pace_mode    = t_pace'($urandom_range(0, 3));
                stretch_left = $urandom_range(16, 96);
            end
            stretch_left--;
            slot_count++;
            case (pace_mode)
                PACE_FREE:    out_ch.ready <= 1'b1;
                PACE_COIN:    out_ch.ready <= ($urandom_range(0, 1) == 1);
                PACE_QUARTER: out_ch.ready <= (slot_count % 4 == 0);
                default:      out_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    function automatic logic signed [31:0] rand_rate();
        case ($urandom_range(0, 4))
            0:       return $urandom();
            1:       return $urandom_range(0, 1023);
            2:       return 32'h7FFF_FFFF - $urandom_range(0, 15);
            3:       return 32'h8000_0000 | $urandom();
            default: return 32'sd0;
        endcase
    endfunction

    function automatic t_in_item make_request(logic [1:0] op, logic signed [31:0] down,
                                              logic signed [31:0] up);
        t_in_item req;
        req.opcode        = op;
        req.download_rate = down;
        req.upload_rate   = up;
        return req;
    endfunction

    function automatic t_in_item rand_request();
        int unsigned pick;
        logic [1:0]  op;
        pick = $urandom_range(0, 99);
        if (pick < 80) op = OP_APPEND;
        else if (pick < 89) op = OP_RENDER;
        else if (pick < 96) op = OP_CLEAR;
        else op = OP_UNUSED;
        return make_request(op, rand_rate(), rand_rate());
    endfunction

    // Offer one request and hold it until the transfer
    task automatic send_item(t_in_item req);
        in_ch.payload <= req;
        in_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        // Insert a gap once the current burst runs out
        if (gap_max > 0) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_columns.size() != 0) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_register(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Field extremes, every opcode, empty and cleared history at reset sizes
    task automatic test_directed_extremes();
        gap_max = 3;
        send_item(make_request(OP_RENDER, 32'sd0, 32'sd0));
        send_item(make_request(OP_APPEND, 32'sd0, 32'sd0));
        send_item(make_request(OP_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(make_request(OP_APPEND, 32'h8000_0000, 32'hFFFF_FFFF));
        send_item(make_request(OP_APPEND, 32'sd1, 32'h0000_0100));
        send_item(make_request(OP_APPEND, 32'hFFFF_FF00, 32'h4000_0000));
        send_item(make_request(OP_UNUSED, 32'h1234_5678, 32'h7FFF_FFFF));
        send_item(make_request(OP_APPEND, 32'h5555_5555, 32'h2AAA_AAAA));
        send_item(make_request(OP_RENDER, 32'sd0, 32'sd0));
        send_item(make_request(OP_CLEAR, 32'h7FFF_FFFF, 32'sd0));
        send_item(make_request(OP_RENDER, 32'sd0, 32'sd0));
        send_item(make_request(OP_APPEND, 32'h0000_0100, 32'h7FFF_FFFF));
        send_item(make_request(OP_RENDER, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    // Saturated, unchanged and unknown register writes
    task automatic test_register_limits();
        int k;
        wait_idle();
        write_register(REG_HISTORY_CAPACITY, 11'd0);
        write_register(REG_COLUMN_COUNT, 11'd0);
        for (k = 0; k < 3; k++) send_item(make_request(OP_APPEND, rand_rate(), rand_rate()));
        send_item(make_request(OP_RENDER, 32'sd0, 32'sd0));
        // Same effective capacity keeps the history
        wait_idle();
        write_register(REG_HISTORY_CAPACITY, 11'd1);
        write_register(REG_COLUMN_COUNT, 11'h7C3);
        send_item(make_request(OP_RENDER, 32'sd0, 32'sd0));
        wait_idle();
        write_register(REG_SPARE_LOW, 11'($urandom()));
        write_register(REG_SPARE_HIGH, 11'($urandom()));
        send_item(make_request(OP_RENDER, 32'sd0, 32'sd0));
        wait_idle();
        write_register(REG_HISTORY_CAPACITY, 11'h7FF);
        send_item(make_request(OP_RENDER, 32'sd0, 32'sd0));
        wait_idle();
        write_register(REG_HISTORY_CAPACITY, 11'h400);
        write_register(REG_COLUMN_COUNT, 11'd127);
        write_register(REG_COLUMN_COUNT, 11'd1);
        for (k = 0; k < 5; k++) send_item(make_request(OP_APPEND, rand_rate(), rand_rate()));
        send_item(make_request(OP_RENDER, 32'sd0, 32'sd0));
    endtask

    // Stall the sink during renders so that input backs up
    task automatic test_output_backpressure();
        int k;
        wait_idle();
        write_register(REG_HISTORY_CAPACITY, 11'd16);
        write_register(REG_COLUMN_COUNT, 11'd8);
        gap_max = 0;
        for (k = 0; k < 20; k++) send_item(make_request(OP_APPEND, rand_rate(), rand_rate()));
        sink_hold_req = 1'b1;
        send_item(make_request(OP_RENDER, 32'sd0, 32'sd0));
        for (k = 0; k < 8; k++) send_item(make_request(OP_APPEND, rand_rate(), rand_rate()));
        send_item(make_request(OP_RENDER, 32'sd0, 32'sd0));
        for (k = 0; k < 3; k++) send_item(make_request(OP_APPEND, rand_rate(), rand_rate()));
        wait_drained();
        send_item(make_request(OP_RENDER, 32'sd0, 32'sd0));
        send_item(make_request(OP_APPEND, rand_rate(), rand_rate()));
        send_item(make_request(OP_APPEND, rand_rate(), rand_rate()));
        send_item(make_request(OP_RENDER, 32'sd0, 32'sd0));
    endtask

    // Random traffic over fixed and random register settings
    task automatic test_random_phases();
        int unsigned phase_cap  [7] = '{2, 3, 1024, 5, 64, 16, 100};
        int unsigned phase_cols [7] = '{2, 64, 64, 7, 2, 16, 33};
        int          phase_gap  [7] = '{4, 0, 8, 12, 3, 0, 5};
        int p, k;
        for (p = 0; p < 10; p++) begin
            wait_idle();
            if (p < 7) begin
                write_register(REG_HISTORY_CAPACITY, 11'(phase_cap[p]));
                write_register(REG_COLUMN_COUNT, 11'(phase_cols[p]));
                gap_max = phase_gap[p];
            end else begin
                write_register(REG_HISTORY_CAPACITY, 11'($urandom_range(0, 2047)));
                write_register(REG_COLUMN_COUNT, 11'($urandom_range(0, 2047)));
                gap_max = $urandom_range(0, 10);
            end
            for (k = 0; k < 36; k++) send_item(rand_request());
        end
    endtask

    initial begin : run_tests
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_register_limits();
        test_output_backpressure();
        test_random_phases();
        wait_idle();
        repeat (END_SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("history_ring_peak_decimator: match");
        end else begin
            $display("history_ring_peak_decimator: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/hrpd_pkg.sv
rtl/core/hrpd_stream_if.sv
rtl/core/hrpd_ram.sv
rtl/core/history_ring_peak_decimator.sv
tb/tb.sv
